// ===== rtl/irct_pkg.sv =====
// ============================================================================
// irct_pkg - shared types and constants for the IRC line tokeniser
// Beat payloads, parse phases, label and status codes, command text table.
// ============================================================================
`default_nettype none

package irct_pkg;

    localparam int MAX_ARGS_DEF = 15;

    // Input beat: one raw byte of the line
    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } line_in_t;

    // Result beat: the byte and its label
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_kind;
        logic [4:0] arg_number;
        logic       field_first;
        logic       line_done;
        logic [1:0] message_kind;
        logic [2:0] status;
    } line_out_t;

    typedef enum logic [3:0] {
        PH_START,
        PH_PREFIX,
        PH_CMD_WAIT,
        PH_CMD,
        PH_ARG_WAIT,
        PH_MIDDLE,
        PH_TRAIL,
        PH_MIDDLE_DROP,
        PH_TRAIL_DROP
    } phase_t;

    // Prefix parts
    localparam logic [1:0] PP_SENDER = 2'd0;
    localparam logic [1:0] PP_USER   = 2'd1;
    localparam logic [1:0] PP_HOST   = 2'd2;

    // Field labels
    localparam logic [2:0] FK_NONE   = 3'd0;
    localparam logic [2:0] FK_SENDER = 3'd1;
    localparam logic [2:0] FK_CMD    = 3'd4;
    localparam logic [2:0] FK_MIDDLE = 3'd5;
    localparam logic [2:0] FK_TRAIL  = 3'd6;

    // Message kinds
    localparam logic [1:0] MK_UNKNOWN = 2'd0;
    localparam logic [1:0] MK_PING    = 2'd1;
    localparam logic [1:0] MK_PRIVMSG = 2'd2;
    localparam logic [1:0] MK_JOIN    = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_CMD      = 3'd1;
    localparam logic [2:0] ST_EMPTY_PFX   = 3'd2;
    localparam logic [2:0] ST_NO_USER     = 3'd3;
    localparam logic [2:0] ST_NO_HOST     = 3'd4;
    localparam logic [2:0] ST_BAD_ARGCNT  = 3'd5;

    // Delimiter bytes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Command table index: 0 PING, 1 PRIVMSG, 2 JOIN
    localparam logic [1:0] CMD_PING    = 2'd0;
    localparam logic [1:0] CMD_PRIVMSG = 2'd1;
    localparam logic [1:0] CMD_JOIN    = 2'd2;

    // Command byte control towards the matcher
    typedef struct packed {
        logic       step;
        logic       feed;
        logic       clear;
        logic [7:0] cmd_byte;
    } cmd_ctl_t;

    // Matcher state after the current beat
    typedef struct packed {
        logic [2:0] match_mask;
        logic [3:0] length;
    } cmd_status_t;

    function automatic logic [3:0] cmd_len(input logic [1:0] sel);
        logic [3:0] len;
        case (sel)
            CMD_PING:    len = 4'd4;
            CMD_PRIVMSG: len = 4'd7;
            CMD_JOIN:    len = 4'd4;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] cmd_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        case ({sel, pos})
            {CMD_PING, 3'd0}:    ch = 8'h50; // P
            {CMD_PING, 3'd1}:    ch = 8'h49; // I
            {CMD_PING, 3'd2}:    ch = 8'h4E; // N
            {CMD_PING, 3'd3}:    ch = 8'h47; // G
            {CMD_PRIVMSG, 3'd0}: ch = 8'h50; // P
            {CMD_PRIVMSG, 3'd1}: ch = 8'h52; // R
            {CMD_PRIVMSG, 3'd2}: ch = 8'h49; // I
            {CMD_PRIVMSG, 3'd3}: ch = 8'h56; // V
            {CMD_PRIVMSG, 3'd4}: ch = 8'h4D; // M
            {CMD_PRIVMSG, 3'd5}: ch = 8'h53; // S
            {CMD_PRIVMSG, 3'd6}: ch = 8'h47; // G
            {CMD_JOIN, 3'd0}:    ch = 8'h4A; // J
            {CMD_JOIN, 3'd1}:    ch = 8'h4F; // O
            {CMD_JOIN, 3'd2}:    ch = 8'h49; // I
            {CMD_JOIN, 3'd3}:    ch = 8'h4E; // N
            default:             ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/irct_cmd_match.sv =====
// ============================================================================
// irct_cmd_match - case-blind command matcher
// Tracks which of PING, PRIVMSG, JOIN still match and the command length.
// ============================================================================
`default_nettype none

module irct_cmd_match (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire irct_pkg::cmd_ctl_t    ctl,
    output irct_pkg::cmd_status_t      cmd
);

    logic [2:0] matches_reg;
    logic [3:0] length_reg;
    logic [2:0] matches_next;
    logic [3:0] length_next;
    logic [7:0] upper;
    logic [2:0] hit;

    // fold a-z to upper case
    always_comb
    begin
        upper = ctl.cmd_byte;
        if (ctl.cmd_byte >= 8'h61 && ctl.cmd_byte <= 8'h7A)
        begin
            upper = ctl.cmd_byte - 8'h20;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hit[i] = (length_reg < irct_pkg::cmd_len(2'(i))) &&
                     (irct_pkg::cmd_char(2'(i), length_reg[2:0]) == upper);
        end
    end

    assign matches_next = ctl.feed ? (matches_reg & hit) : matches_reg;
    assign length_next  = (ctl.feed && length_reg != 4'd15) ? length_reg + 4'd1 : length_reg;

    assign cmd.match_mask = matches_next;
    assign cmd.length     = length_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matches_reg <= 3'b111;
            length_reg  <= 4'd0;
        end
        else if (ctl.step)
        begin
            if (ctl.clear)
            begin
                matches_reg <= 3'b111;
                length_reg  <= 4'd0;
            end
            else
            begin
                matches_reg <= matches_next;
                length_reg  <= length_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/irct_parser.sv =====
// ============================================================================
// irct_parser - line phase state machine and byte labelling
// Holds the parse phase, prefix part and argument count; builds the result.
// ============================================================================
`default_nettype none

module irct_parser #(
    parameter int MAX_ARGS = irct_pkg::MAX_ARGS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire irct_pkg::line_in_t    beat,
    input  wire irct_pkg::cmd_status_t cmd,
    output irct_pkg::cmd_ctl_t         cmd_ctl,
    output irct_pkg::line_out_t        result
);

    irct_pkg::phase_t phase_reg, phase_next;
    logic [1:0] part_reg, part_next;
    logic       inside_reg, inside_next;
    logic [4:0] count_reg, count_next;
    logic [2:0] err_reg, err_next, err_end;

    logic is_sp, is_colon, is_bang, is_at, at_limit;
    logic [1:0] kind_code;

    assign is_sp    = beat.line_byte == irct_pkg::CH_SPACE;
    assign is_colon = beat.line_byte == irct_pkg::CH_COLON;
    assign is_bang  = beat.line_byte == irct_pkg::CH_BANG;
    assign is_at    = beat.line_byte == irct_pkg::CH_AT;
    assign at_limit = count_reg >= 5'(MAX_ARGS);

    // keep only the first error
    function automatic logic [2:0] note(input logic [2:0] e, input logic [2:0] c);
        return (e != irct_pkg::ST_OK) ? e : c;
    endfunction

    // error raised when a prefix part is closed
    function automatic logic [2:0] close_code(input logic [1:0] part, input logic has_bytes);
        logic [2:0] c;
        c = irct_pkg::ST_OK;
        if (!has_bytes)
        begin
            if (part == irct_pkg::PP_SENDER)
                c = irct_pkg::ST_EMPTY_PFX;
            else if (part == irct_pkg::PP_USER)
                c = irct_pkg::ST_NO_USER;
            else
                c = irct_pkg::ST_NO_HOST;
        end
        else if (part == irct_pkg::PP_USER)
        begin
            c = irct_pkg::ST_NO_HOST;
        end
        return c;
    endfunction

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        part_next   = part_reg;
        inside_next = inside_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        case (phase_reg)
            irct_pkg::PH_PREFIX:
            begin
                if (is_sp)
                begin
                    err_next   = note(err_reg, close_code(part_reg, inside_reg));
                    phase_next = irct_pkg::PH_CMD_WAIT;
                end
                else if (part_reg == irct_pkg::PP_SENDER && (is_bang || is_at))
                begin
                    if (!inside_reg)
                        err_next = note(err_reg, irct_pkg::ST_EMPTY_PFX);
                    part_next   = is_bang ? irct_pkg::PP_USER : irct_pkg::PP_HOST;
                    inside_next = 1'b0;
                end
                else if (part_reg == irct_pkg::PP_USER && is_at)
                begin
                    if (!inside_reg)
                        err_next = note(err_reg, irct_pkg::ST_NO_USER);
                    part_next   = irct_pkg::PP_HOST;
                    inside_next = 1'b0;
                end
                else if (!(part_reg == irct_pkg::PP_HOST && is_at))
                begin
                    inside_next = 1'b1;
                end
            end
            irct_pkg::PH_CMD_WAIT:
            begin
                if (!is_sp)
                    phase_next = irct_pkg::PH_CMD;
            end
            irct_pkg::PH_CMD:
            begin
                if (is_sp)
                    phase_next = irct_pkg::PH_ARG_WAIT;
            end
            irct_pkg::PH_ARG_WAIT:
            begin
                if (is_sp)
                begin
                    phase_next = irct_pkg::PH_ARG_WAIT;
                end
                else if (at_limit)
                begin
                    phase_next = is_colon ? irct_pkg::PH_TRAIL_DROP : irct_pkg::PH_MIDDLE_DROP;
                end
                else if (is_colon)
                begin
                    count_next  = count_reg + 5'd1;
                    phase_next  = irct_pkg::PH_TRAIL;
                    inside_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg + 5'd1;
                    phase_next = irct_pkg::PH_MIDDLE;
                end
            end
            irct_pkg::PH_MIDDLE, irct_pkg::PH_MIDDLE_DROP:
            begin
                if (is_sp)
                    phase_next = irct_pkg::PH_ARG_WAIT;
            end
            irct_pkg::PH_TRAIL:
            begin
                inside_next = 1'b1;
            end
            irct_pkg::PH_TRAIL_DROP:
            begin
                phase_next = irct_pkg::PH_TRAIL_DROP;
            end
            default:
            begin
                if (is_colon)
                begin
                    phase_next  = irct_pkg::PH_PREFIX;
                    part_next   = irct_pkg::PP_SENDER;
                    inside_next = 1'b0;
                end
                else if (!is_sp)
                begin
                    phase_next = irct_pkg::PH_CMD;
                end
            end
        endcase
        // line ending inside the prefix closes the open part
        err_end = (phase_next == irct_pkg::PH_PREFIX)
                ? note(err_next, close_code(part_next, inside_next)) : err_next;
    end

    // command matcher control
    always_comb
    begin
        cmd_ctl.step     = step;
        cmd_ctl.clear    = beat.line_end;
        cmd_ctl.cmd_byte = beat.line_byte;
        case (phase_reg)
            irct_pkg::PH_START:    cmd_ctl.feed = !is_sp && !is_colon;
            irct_pkg::PH_CMD_WAIT: cmd_ctl.feed = !is_sp;
            irct_pkg::PH_CMD:      cmd_ctl.feed = !is_sp;
            default:               cmd_ctl.feed = 1'b0;
        endcase
    end

    // recognised command, first match wins
    always_comb
    begin
        if (cmd.match_mask[0] && cmd.length == irct_pkg::cmd_len(irct_pkg::CMD_PING))
            kind_code = irct_pkg::MK_PING;
        else if (cmd.match_mask[1] && cmd.length == irct_pkg::cmd_len(irct_pkg::CMD_PRIVMSG))
            kind_code = irct_pkg::MK_PRIVMSG;
        else if (cmd.match_mask[2] && cmd.length == irct_pkg::cmd_len(irct_pkg::CMD_JOIN))
            kind_code = irct_pkg::MK_JOIN;
        else
            kind_code = irct_pkg::MK_UNKNOWN;
    end

    // outputs
    always_comb
    begin
        result              = '0;
        result.out_byte     = beat.line_byte;
        result.line_done    = beat.line_end;
        result.field_kind   = irct_pkg::FK_NONE;
        result.arg_number   = 5'd0;
        result.field_first  = 1'b0;
        result.message_kind = irct_pkg::MK_UNKNOWN;
        result.status       = irct_pkg::ST_OK;
        case (phase_reg)
            irct_pkg::PH_PREFIX:
            begin
                if (!is_sp
                    && !(part_reg == irct_pkg::PP_SENDER && (is_bang || is_at))
                    && !(part_reg != irct_pkg::PP_SENDER && is_at))
                begin
                    result.field_kind  = irct_pkg::FK_SENDER + {1'b0, part_reg};
                    result.field_first = !inside_reg;
                end
            end
            irct_pkg::PH_CMD_WAIT:
            begin
                if (!is_sp)
                begin
                    result.field_kind  = irct_pkg::FK_CMD;
                    result.field_first = 1'b1;
                end
            end
            irct_pkg::PH_CMD:
            begin
                if (!is_sp)
                    result.field_kind = irct_pkg::FK_CMD;
            end
            irct_pkg::PH_ARG_WAIT:
            begin
                if (!is_sp && !at_limit && !is_colon)
                begin
                    result.field_kind  = irct_pkg::FK_MIDDLE;
                    result.field_first = 1'b1;
                    result.arg_number  = count_reg;
                end
            end
            irct_pkg::PH_MIDDLE:
            begin
                if (!is_sp)
                begin
                    result.field_kind = irct_pkg::FK_MIDDLE;
                    result.arg_number = count_reg - 5'd1;
                end
            end
            irct_pkg::PH_TRAIL:
            begin
                result.field_kind  = irct_pkg::FK_TRAIL;
                result.arg_number  = count_reg - 5'd1;
                result.field_first = !inside_reg;
            end
            irct_pkg::PH_START:
            begin
                if (!is_sp && !is_colon)
                begin
                    result.field_kind  = irct_pkg::FK_CMD;
                    result.field_first = 1'b1;
                end
            end
            default:
            begin
                result.field_kind = irct_pkg::FK_NONE;
            end
        endcase

        if (beat.line_end)
        begin
            if (err_end != irct_pkg::ST_OK)
                result.status = err_end;
            else if (phase_next == irct_pkg::PH_START || phase_next == irct_pkg::PH_PREFIX
                     || phase_next == irct_pkg::PH_CMD_WAIT)
                result.status = irct_pkg::ST_NO_CMD;
            else if ((kind_code == irct_pkg::MK_PING || kind_code == irct_pkg::MK_JOIN)
                     && (count_next < 5'd1 || count_next > 5'd2))
                result.status = irct_pkg::ST_BAD_ARGCNT;
            else if (kind_code == irct_pkg::MK_PRIVMSG && count_next != 5'd2)
                result.status = irct_pkg::ST_BAD_ARGCNT;
            else
                result.message_kind = kind_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= irct_pkg::PH_START;
            part_reg   <= irct_pkg::PP_SENDER;
            inside_reg <= 1'b0;
            count_reg  <= 5'd0;
            err_reg    <= irct_pkg::ST_OK;
        end
        else if (step)
        begin
            if (beat.line_end)
            begin
                phase_reg  <= irct_pkg::PH_START;
                part_reg   <= irct_pkg::PP_SENDER;
                inside_reg <= 1'b0;
                count_reg  <= 5'd0;
                err_reg    <= irct_pkg::ST_OK;
            end
            else
            begin
                phase_reg  <= phase_next;
                part_reg   <= part_next;
                inside_reg <= inside_next;
                count_reg  <= count_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/irc_line_tokenizer.sv =====
// ============================================================================
// irc_line_tokenizer - labels the bytes of an IRC message line
// Input register, one pass of phase logic, result register; one byte a cycle unless the receiver stalls.
// ============================================================================
// Usage:
//   in_valid/in_ready/in_data carry one raw byte of the line per beat, with
//   line_end set on the final byte. out_valid/out_ready/out_data return one
//   result beat per input beat, in order: the byte, its field label, the
//   argument number and, on the final byte, the message kind and status.
//   An input beat passes through the input register, then the result register,
//   to become a result beat. Throughput is one byte per cycle while the receiver
//   keeps out_ready high, with a single phase update between the two registers.
//   Reset clears the parse state to start of line and empties both register
//   stages. After the final byte of a line the parse state returns to start
//   of line, so the next line may follow in the very next cycle.
//   If the receiver stalls, the result register holds its beat, the input
//   register fills behind it and in_ready then drops until out_ready returns.
// ============================================================================
`default_nettype none

module irc_line_tokenizer #(
    parameter int MAX_ARGS = irct_pkg::MAX_ARGS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire irct_pkg::line_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output irct_pkg::line_out_t      out_data
);

    // input stage
    logic                 in_valid_reg;
    irct_pkg::line_in_t   in_data_reg;

    // result stage
    logic                 out_valid_reg;
    irct_pkg::line_out_t  out_data_reg;

    logic                  advance;   // result register can take a beat
    logic                  step;      // parse the held byte this cycle
    irct_pkg::cmd_ctl_t    cmd_ctl;
    irct_pkg::cmd_status_t cmd_status;
    irct_pkg::line_out_t   result;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    irct_parser #(
        .MAX_ARGS (MAX_ARGS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .beat    (in_data_reg),
        .cmd     (cmd_status),
        .cmd_ctl (cmd_ctl),
        .result  (result)
    );

    irct_cmd_match u_cmd_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cmd_ctl),
        .cmd   (cmd_status)
    );

    // input register: refilled whenever its beat moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // summary fields only on the final byte of a line
    a_summary_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.line_done |->
            out_data.message_kind == irct_pkg::MK_UNKNOWN
            && out_data.status == irct_pkg::ST_OK)
        else $error("summary fields set on a byte that is not the last");

    // a recognised message is always reported with status ok
    a_kind_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.message_kind != irct_pkg::MK_UNKNOWN |->
            out_data.status == irct_pkg::ST_OK)
        else $error("message kind reported together with an error");

    // argument number only on argument bytes
    a_argn_on_args: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.field_kind != irct_pkg::FK_MIDDLE
        && out_data.field_kind != irct_pkg::FK_TRAIL |->
            out_data.arg_number == 5'd0)
        else $error("argument number on a byte outside an argument");

    // with the result stage empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while result stage empty");

endmodule

`default_nettype wire
